[rtl/pls_pkg.sv]
package pls_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;
	localparam int ST_W  = 2;
	localparam int LEN_W = 5;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_COUNT     = 3'd6;
	localparam logic [OP_W-1:0] OP_LIST      = 3'd7;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch the input beat
		logic exec;     // run the latched command, load the first result
		logic emit;     // load the next listed element and rotate
	} pls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // output register can take a result this cycle
		logic is_list;
		logic empty;
		logic final_elem;  // element at the front is the last one to list
	} pls_stat_t;

endpackage

[rtl/pls_ctrl.sv]
module pls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pls_pkg::pls_stat_t  stat,
	output pls_pkg::pls_cmd_t   cmd
);
	import pls_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LIST = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.is_list && !stat.empty && !stat.final_elem) begin
						state_d = S_LIST;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.final_elem) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/pls_datapath.sv]
module pls_datapath #(
	parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pls_pkg::pls_cmd_t               cmd,
	output pls_pkg::pls_stat_t              stat,
	input  logic [pls_pkg::OP_W-1:0]        operation,
	input  logic signed [pls_pkg::VAL_W-1:0] value,
	input  logic [pls_pkg::POS_W-1:0]       position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pls_pkg::ST_W-1:0]        status,
	output logic signed [pls_pkg::VAL_W-1:0] element,
	output logic [pls_pkg::LEN_W-1:0]       length,
	output logic                            last
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EP_W  = POS_W + 1;

	// latched command
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] lidx_q;
	logic [VAL_W-1:0] cell_q [DEPTH];

	logic             out_valid_q;
	logic [ST_W-1:0]  status_q;
	logic [VAL_W-1:0] element_q;
	logic [LEN_W-1:0] length_q;
	logic             last_q;

	logic [EP_W-1:0]  ep;
	logic [EP_W-1:0]  cnt7;
	logic             is_ins, is_del;
	logic             ins_ok, del_ok, do_emit, load;
	logic [ST_W-1:0]  res_st;
	logic [CNT_W+LEN_W-1:0] len_ext;

	assign cnt7 = EP_W'(cnt_q);

	always_comb begin
		is_ins = 1'b0;
		is_del = 1'b0;
		ep     = '0;
		case (op_q)
			OP_INS_FRONT: begin is_ins = 1'b1; ep = EP_W'(1); end
			OP_INS_BACK:  begin is_ins = 1'b1; ep = cnt7 + EP_W'(1); end
			OP_INS_AT:    begin is_ins = 1'b1; ep = EP_W'(pos_q); end
			OP_DEL_FRONT: begin is_del = 1'b1; ep = EP_W'(1); end
			OP_DEL_BACK:  begin is_del = 1'b1; ep = cnt7; end
			OP_DEL_AT:    begin is_del = 1'b1; ep = EP_W'(pos_q); end
			default:      begin ep = '0; end
		endcase
	end

	always_comb begin
		res_st = ST_OK;
		ins_ok = 1'b0;
		del_ok = 1'b0;
		if (is_ins) begin
			if (ep == '0 || ep > cnt7 + EP_W'(1)) begin
				res_st = ST_BADPOS;
			end else if (cnt_q == CNT_W'(DEPTH)) begin
				res_st = ST_FULL;
			end else begin
				ins_ok = 1'b1;
			end
		end else if (is_del) begin
			if (cnt_q == '0) begin
				res_st = ST_EMPTY;
			end else if (ep == '0 || ep > cnt7) begin
				res_st = ST_BADPOS;
			end else begin
				del_ok = 1'b1;
			end
		end else if (op_q == OP_LIST && cnt_q == '0) begin
			res_st = ST_EMPTY;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.exec && ins_ok) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.exec && del_ok) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign do_emit = cmd.emit || (cmd.exec && op_q == OP_LIST && cnt_q != '0);
	assign load    = cmd.exec || cmd.emit;
	assign len_ext = {{LEN_W{1'b0}}, cnt_d};

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.is_list    = (op_q == OP_LIST);
	assign stat.empty      = (cnt_q == '0);
	assign stat.final_elem = (lidx_q + CNT_W'(1) == cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			val_q <= value;
			pos_q <= position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			lidx_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (cmd.capture) begin
				lidx_q <= '0;
			end else if (do_emit) begin
				lidx_q <= lidx_q + CNT_W'(1);
			end
		end
	end

	// Row of cells. Insert opens a gap at ep-1, delete closes it, and a list
	// beat rotates the first cnt cells left by one so the front is always next.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [EP_W-1:0] POS1 = EP_W'(i + 1);
		logic [VAL_W-1:0] up_nb, dn_nb;

		if (i == 0) begin : g_lo
			assign dn_nb = cell_q[0];
		end else begin : g_mid
			assign dn_nb = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign up_nb = cell_q[i];
		end else begin : g_top
			assign up_nb = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && ins_ok) begin
				if (POS1 == ep) begin
					cell_q[i] <= val_q;
				end else if (POS1 > ep) begin
					cell_q[i] <= dn_nb;
				end
			end else if (cmd.exec && del_ok) begin
				if (POS1 >= ep) begin
					cell_q[i] <= up_nb;
				end
			end else if (do_emit) begin
				if (POS1 < cnt7) begin
					cell_q[i] <= up_nb;
				end else if (POS1 == cnt7) begin
					cell_q[i] <= cell_q[0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			length_q <= len_ext[LEN_W-1:0];
			if (do_emit) begin
				status_q  <= ST_OK;
				element_q <= cell_q[0];
				last_q    <= stat.final_elem;
			end else begin
				status_q  <= res_st;
				element_q <= '0;
				last_q    <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign length    = length_q;
	assign last      = last_q;

endmodule

[rtl/positional_list_store_core.sv]
// Positional list store: an ordered list of up to DEPTH signed 32-bit values.
//
// Input channel (in_valid/in_ready) carries one command per beat: operation,
// value, position. Output channel (out_valid/out_ready) carries result beats:
// status, element, length, last. Every command gives one result beat with
// last set, except list, which gives one beat per element (front first, last
// on the final one) or a single empty-status beat when the list is empty.
//
// Flow: a command is taken into an input register and executed from there
// once the output register is free; its first result is then registered on
// the output. in_ready is high only in the idle state, so one command is in
// flight at a time. The row of cells shifts in parallel, so insert and delete
// cost the same at any position; a list emits one element per cycle while the
// receiver takes them, rotating the row so the front cell is always next out.
//
// Reset clears the element count and the output valid; slot contents are
// not cleared and are only read below the count. When the receiver stalls,
// the output register holds its beat and execution waits; a new command is
// still accepted into the input register while a result is waiting.
module positional_list_store_core #(
	parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pls_pkg::OP_W-1:0]         operation,
	input  logic signed [pls_pkg::VAL_W-1:0] value,
	input  logic [pls_pkg::POS_W-1:0]        position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pls_pkg::ST_W-1:0]         status,
	output logic signed [pls_pkg::VAL_W-1:0] element,
	output logic [pls_pkg::LEN_W-1:0]        length,
	output logic                             last
);
	import pls_pkg::*;

	pls_cmd_t  cmd;
	pls_stat_t stat;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pls_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.element   (element),
		.length    (length),
		.last      (last)
	);

endmodule

[rtl/pls_checker.sv]
module pls_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [pls_pkg::ST_W-1:0]         status,
	input logic signed [pls_pkg::VAL_W-1:0] element,
	input logic [pls_pkg::LEN_W-1:0]        length,
	input logic                             last
);
	import pls_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(element)
			&& $stable(length) && $stable(last))
		else $error("result beat changed under stall");

	// one command at a time: busy right after a command beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while busy");

	// failed commands give a single zero-element beat
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && element == '0)
		else $error("error status on non-final or non-zero beat");

	// no new command while a list is still being emitted
	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("command taken in the middle of a list");

endmodule

bind positional_list_store_core pls_checker u_pls_checker (.*);
